[src/metal_reflect_scatter_defines.svh]
// assertion macros for the metal_reflect_scatter checker
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef METAL_REFLECT_SCATTER_DEFINES_SVH
`define METAL_REFLECT_SCATTER_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define MSR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("msr checker: property failed");

// next-cycle implication, quiet while reset is held
`define MSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("msr checker: property failed");

`endif

[src/msr_pkg.sv]
// shared widths, register codes, stage counts and sideband type
// for the metal reflect scatter pipeline; no dependencies
package msr_pkg;

    localparam int DIR_W     = 24;
    localparam int VEC_W     = 16;
    localparam int MAG_W     = 24;
    localparam int SHF_W     = 5;
    localparam int SQ_W      = 48;
    localparam int LEN_W     = 24;
    localparam int SR_W      = 27;
    localparam int REM_W     = 25;
    localparam int QUO_W     = 15;
    localparam int NORM_MSB  = 22;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;
    localparam int ALB_W     = 16;
    localparam int FUZZ_W    = 15;

    localparam logic [ALB_W-1:0]  ALB_ONE  = 16'd32768;
    localparam logic [FUZZ_W-1:0] FUZZ_ONE = 15'd16384;

    localparam logic [CFG_IDX_W-1:0] CFG_ALB_RED   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALB_GREEN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALB_BLUE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FUZZ      = 4'd3;

    localparam int NORM_LAT    = 4;
    localparam int SQRT_STAGES = 12;
    localparam int DIV_STAGES  = 5;
    localparam int REFL_LAT    = 6;
    localparam int MSR_LAT     = NORM_LAT + SQRT_STAGES + DIV_STAGES + REFL_LAT;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic [MAG_W-1:0]        t_mag;

    // control and pass-along data that rides beside each item
    typedef struct packed {
        logic           valid;
        logic           zero;
        logic [2:0]     neg;
        t_vec [2:0]     nrm;
        t_vec [2:0]     jit;
    } t_side;

    function automatic logic [ALB_W-1:0] sat_alb(input logic [CFG_DAT_W-1:0] v);
        sat_alb = (v > ALB_ONE) ? ALB_ONE : v;
    endfunction

    function automatic logic [FUZZ_W-1:0] sat_fuzz(input logic [CFG_DAT_W-1:0] v);
        sat_fuzz = (v[FUZZ_W-1:0] > FUZZ_ONE) ? FUZZ_ONE : v[FUZZ_W-1:0];
    endfunction

endpackage

[src/metal_reflect_scatter.sv]
// top level of the fuzzy metal reflection pipeline: configuration registers
// and the chain msr_norm, msr_sqrt, msr_div, msr_reflect; depends on msr_pkg
//
// channel   handshake                     payload
// input     start high, busy low          i_dir_*, i_normal_*, i_jitter_*
// result    o_valid high for one cycle    o_out_dir_*, o_scatters, o_atten_*
// config    i_cfg_valid and o_cfg_ready   i_cfg_index, i_cfg_data
//
// one item per cycle; each result comes out at the end of the pipeline,
// which runs through the 12-stage square root and the 5-stage divider;
// busy stays low and the result side has no back pressure
// synchronous active-low reset clears the valid bits and presets the configuration registers
module metal_reflect_scatter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [msr_pkg::DIR_W-1:0]  i_dir_x,
    input  logic signed [msr_pkg::DIR_W-1:0]  i_dir_y,
    input  logic signed [msr_pkg::DIR_W-1:0]  i_dir_z,
    input  logic signed [msr_pkg::VEC_W-1:0]  i_normal_x,
    input  logic signed [msr_pkg::VEC_W-1:0]  i_normal_y,
    input  logic signed [msr_pkg::VEC_W-1:0]  i_normal_z,
    input  logic signed [msr_pkg::VEC_W-1:0]  i_jitter_x,
    input  logic signed [msr_pkg::VEC_W-1:0]  i_jitter_y,
    input  logic signed [msr_pkg::VEC_W-1:0]  i_jitter_z,
    output logic                              o_valid,
    output logic signed [msr_pkg::VEC_W-1:0]  o_out_dir_x,
    output logic signed [msr_pkg::VEC_W-1:0]  o_out_dir_y,
    output logic signed [msr_pkg::VEC_W-1:0]  o_out_dir_z,
    output logic                              o_scatters,
    output logic [msr_pkg::ALB_W-1:0]         o_atten_red,
    output logic [msr_pkg::ALB_W-1:0]         o_atten_green,
    output logic [msr_pkg::ALB_W-1:0]         o_atten_blue,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [msr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [msr_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import msr_pkg::*;

    logic [ALB_W-1:0]   r_alb_red, r_alb_green, r_alb_blue;
    logic [FUZZ_W-1:0]  r_fuzz;
    t_side              in_side, norm_side, sqrt_side, div_side;
    logic [2:0][DIR_W-1:0] in_dir;
    t_mag               norm_mag [3];
    t_mag               sqrt_mag [3];
    logic [SQ_W-1:0]    norm_l2;
    logic [LEN_W-1:0]   sqrt_len;
    logic [QUO_W-1:0]   div_quo [3];
    t_vec               refl_dir [3];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alb_red   <= ALB_ONE;
            r_alb_green <= ALB_ONE;
            r_alb_blue  <= ALB_ONE;
            r_fuzz      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ALB_RED:   r_alb_red   <= sat_alb(i_cfg_data);
                CFG_ALB_GREEN: r_alb_green <= sat_alb(i_cfg_data);
                CFG_ALB_BLUE:  r_alb_blue  <= sat_alb(i_cfg_data);
                CFG_FUZZ:      r_fuzz      <= sat_fuzz(i_cfg_data);
                default: ;
            endcase
        end
    end

    // item entering the pipeline
    always_comb begin
        in_side.valid  = start && !busy;
        in_side.zero   = 1'b0;
        in_side.neg    = '0;
        in_side.nrm[0] = i_normal_x;
        in_side.nrm[1] = i_normal_y;
        in_side.nrm[2] = i_normal_z;
        in_side.jit[0] = i_jitter_x;
        in_side.jit[1] = i_jitter_y;
        in_side.jit[2] = i_jitter_z;
        in_dir[0]      = i_dir_x;
        in_dir[1]      = i_dir_y;
        in_dir[2]      = i_dir_z;
    end

    msr_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (in_side),
        .i_dir   (in_dir),
        .o_side  (norm_side),
        .o_mag   (norm_mag),
        .o_l2    (norm_l2)
    );

    msr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (norm_side),
        .i_mag   (norm_mag),
        .i_l2    (norm_l2),
        .o_side  (sqrt_side),
        .o_mag   (sqrt_mag),
        .o_len   (sqrt_len)
    );

    msr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (sqrt_side),
        .i_mag   (sqrt_mag),
        .i_len   (sqrt_len),
        .o_side  (div_side),
        .o_quo   (div_quo)
    );

    msr_reflect u_reflect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_side     (div_side),
        .i_quo      (div_quo),
        .i_fuzz     (r_fuzz),
        .o_valid    (o_valid),
        .o_dir      (refl_dir),
        .o_scatters (o_scatters)
    );

    assign o_out_dir_x   = refl_dir[0];
    assign o_out_dir_y   = refl_dir[1];
    assign o_out_dir_z   = refl_dir[2];
    assign o_atten_red   = r_alb_red;
    assign o_atten_green = r_alb_green;
    assign o_atten_blue  = r_alb_blue;

endmodule

[src/msr_norm.sv]
// front stages: magnitudes, shared left shift, squares and squared length
// depends on msr_pkg
module msr_norm (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  msr_pkg::t_side                         i_side,
    input  logic [2:0][msr_pkg::DIR_W-1:0]         i_dir,
    output msr_pkg::t_side                         o_side,
    output msr_pkg::t_mag                          o_mag [3],
    output logic [msr_pkg::SQ_W-1:0]               o_l2
);
    import msr_pkg::*;

    t_side              r_side1, r_side2, r_side3, r_side4;
    t_side              n_side1, n_side2;
    t_mag               r_m1 [3];
    t_mag               r_m2 [3];
    t_mag               r_m3 [3];
    t_mag               r_m4 [3];
    t_mag               n_m1 [3];
    t_mag               n_m2 [3];
    logic [SQ_W-1:0]    r_sq [3];
    logic [SQ_W-1:0]    r_l2;
    t_mag               mx;
    logic [SHF_W-1:0]   msb;
    logic [SHF_W-1:0]   sh;

    // stage 1: sign and magnitude of each component
    always_comb begin
        n_side1 = i_side;
        for (int i = 0; i < 3; i++) begin
            n_side1.neg[i] = i_dir[i][DIR_W-1];
            n_m1[i] = i_dir[i][DIR_W-1] ? (~i_dir[i] + 1'b1) : i_dir[i];
        end
    end

    // stage 2: largest magnitude, leading one and common shift
    always_comb begin
        mx = r_m1[0];
        if (r_m1[1] > mx) mx = r_m1[1];
        if (r_m1[2] > mx) mx = r_m1[2];
        msb = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (mx[b]) msb = SHF_W'(b);
        end
        sh = (msb >= SHF_W'(NORM_MSB)) ? '0 : SHF_W'(NORM_MSB) - msb;
        n_side2 = r_side1;
        n_side2.zero = (mx == '0);
        for (int i = 0; i < 3; i++) begin
            n_m2[i] = r_m1[i] << sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1.valid <= 1'b0;
            r_side2.valid <= 1'b0;
            r_side3.valid <= 1'b0;
            r_side4.valid <= 1'b0;
        end else begin
            r_side1 <= n_side1;
            r_side2 <= n_side2;
            r_side3 <= r_side2;
            r_side4 <= r_side3;
        end
        for (int i = 0; i < 3; i++) begin
            r_m1[i] <= n_m1[i];
            r_m2[i] <= n_m2[i];
            r_m3[i] <= r_m2[i];
            r_m4[i] <= r_m3[i];
            // stage 3: squares
            r_sq[i] <= r_m2[i] * r_m2[i];
        end
        // stage 4: squared length
        r_l2 <= r_sq[0] + r_sq[1] + r_sq[2];
    end

    assign o_side = r_side4;
    assign o_mag  = r_m4;
    assign o_l2   = r_l2;

endmodule

[src/msr_sqrt.sv]
// pipelined integer square root, two result bits per stage
// depends on msr_pkg
module msr_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  msr_pkg::t_side              i_side,
    input  msr_pkg::t_mag               i_mag [3],
    input  logic [msr_pkg::SQ_W-1:0]    i_l2,
    output msr_pkg::t_side              o_side,
    output msr_pkg::t_mag               o_mag [3],
    output logic [msr_pkg::LEN_W-1:0]   o_len
);
    import msr_pkg::*;

    logic [SR_W-1:0]  r_rem  [SQRT_STAGES];
    logic [LEN_W-1:0] r_root [SQRT_STAGES];
    logic [SQ_W-1:0]  r_rad  [SQRT_STAGES];
    t_mag             r_mag  [SQRT_STAGES][3];
    t_side            r_side [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
        logic [SR_W-1:0]  rem_in, rem, trial;
        logic [LEN_W-1:0] root_in, root;
        logic [SQ_W-1:0]  rad_in;
        t_mag             mag_in [3];
        t_side            side_in;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_l2;
            assign mag_in  = i_mag;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign rad_in  = r_rad[g-1];
            assign mag_in  = r_mag[g-1];
            assign side_in = r_side[g-1];
        end

        // two restoring steps
        always_comb begin
            rem  = rem_in;
            root = root_in;
            for (int k = 0; k < 2; k++) begin
                rem   = {rem[SR_W-3:0], rad_in[SQ_W-1-2*(2*g+k) -: 2]};
                trial = {1'b0, root, 2'b01};
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = {root[LEN_W-2:0], 1'b1};
                end else begin
                    root = {root[LEN_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= rem;
            r_root[g] <= root;
            r_rad[g]  <= rad_in;
            r_mag[g]  <= mag_in;
            if (!i_rst_n) begin
                r_side[g].valid <= 1'b0;
            end else begin
                r_side[g] <= side_in;
            end
        end
    end

    assign o_side = r_side[SQRT_STAGES-1];
    assign o_mag  = r_mag[SQRT_STAGES-1];
    assign o_len  = r_root[SQRT_STAGES-1];

endmodule

[src/msr_div.sv]
// pipelined restoring divider, three lanes, three quotient bits per stage
// gives magnitude * 2^14 / length; depends on msr_pkg
module msr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  msr_pkg::t_side              i_side,
    input  msr_pkg::t_mag               i_mag [3],
    input  logic [msr_pkg::LEN_W-1:0]   i_len,
    output msr_pkg::t_side              o_side,
    output logic [msr_pkg::QUO_W-1:0]   o_quo [3]
);
    import msr_pkg::*;

    logic [REM_W-1:0] r_rem  [DIV_STAGES][3];
    logic [QUO_W-1:0] r_quo  [DIV_STAGES][3];
    logic [LEN_W-1:0] r_len  [DIV_STAGES];
    t_side            r_side [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic [REM_W-1:0] rem_in [3];
        logic [QUO_W-1:0] quo_in [3];
        logic [REM_W-1:0] rem    [3];
        logic [QUO_W-1:0] quo    [3];
        logic [LEN_W-1:0] len_in;
        t_side            side_in;

        if (g == 0) begin : g_first
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign rem_in[i] = {1'b0, i_mag[i]};
                assign quo_in[i] = '0;
            end
            assign len_in  = i_len;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign quo_in  = r_quo[g-1];
            assign len_in  = r_len[g-1];
            assign side_in = r_side[g-1];
        end

        // first step compares without doubling, later steps double first
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rem[i] = rem_in[i];
                quo[i] = quo_in[i];
                for (int k = 0; k < 3; k++) begin
                    if (!(g == 0 && k == 0)) rem[i] = {rem[i][REM_W-2:0], 1'b0};
                    if (rem[i] >= {1'b0, len_in}) begin
                        rem[i] = rem[i] - {1'b0, len_in};
                        quo[i] = {quo[i][QUO_W-2:0], 1'b1};
                    end else begin
                        quo[i] = {quo[i][QUO_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= rem;
            r_quo[g]  <= quo;
            r_len[g]  <= len_in;
            if (!i_rst_n) begin
                r_side[g].valid <= 1'b0;
            end else begin
                r_side[g] <= side_in;
            end
        end
    end

    assign o_side = r_side[DIV_STAGES-1];
    assign o_quo  = r_quo[DIV_STAGES-1];

endmodule

[src/msr_reflect.sv]
// back stages: unit vector, dot with normal, reflection, fuzz, saturation
// and the outward flag; depends on msr_pkg
module msr_reflect (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  msr_pkg::t_side              i_side,
    input  logic [msr_pkg::QUO_W-1:0]   i_quo [3],
    input  logic [msr_pkg::FUZZ_W-1:0]  i_fuzz,
    output logic                        o_valid,
    output msr_pkg::t_vec               o_dir [3],
    output logic                        o_scatters
);
    import msr_pkg::*;

    t_side               r_side1, r_side2, r_side3, r_side4, r_side5;
    logic signed [15:0]  r_u1 [3];
    logic signed [15:0]  r_u2 [3];
    logic signed [15:0]  r_u3 [3];
    logic signed [31:0]  r_p1 [3];
    logic signed [31:0]  r_dot;
    logic signed [47:0]  r_a  [3];
    logic signed [31:0]  r_b  [3];
    logic signed [15:0]  r_r4 [3];
    logic signed [15:0]  r_r5 [3];
    logic signed [31:0]  r_s5 [3];
    logic signed [15:0]  n_u  [3];
    logic signed [15:0]  n_r  [3];
    logic signed [47:0]  a_rnd [3];
    logic signed [31:0]  b_rnd [3];
    logic signed [23:0]  sum   [3];
    logic signed [33:0]  sdot;
    logic                r_valid;
    t_vec                r_dir [3];
    logic                r_scatters;

    // signed unit components
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_u[i] = i_side.neg[i] ? -$signed({1'b0, i_quo[i]}) : $signed({1'b0, i_quo[i]});
        end
    end

    // reflection with round half up, fuzz, saturation; zero direction gives zero
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_rnd[i] = r_a[i] + 48'sd67108864;
            b_rnd[i] = r_b[i] + 32'sd8192;
            sum[i]   = {{8{r_u3[i][15]}}, r_u3[i]}
                     - {{3{a_rnd[i][47]}}, a_rnd[i][47:27]}
                     + {{6{b_rnd[i][31]}}, b_rnd[i][31:14]};
            if (r_side3.zero)               n_r[i] = '0;
            else if (sum[i] > 24'sd32767)   n_r[i] = 16'sh7fff;
            else if (sum[i] < -24'sd32768)  n_r[i] = -16'sh8000;
            else                            n_r[i] = sum[i][15:0];
        end
        sdot = r_s5[0] + r_s5[1] + r_s5[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1.valid <= 1'b0;
            r_side2.valid <= 1'b0;
            r_side3.valid <= 1'b0;
            r_side4.valid <= 1'b0;
            r_side5.valid <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_side1 <= i_side;
            r_side2 <= r_side1;
            r_side3 <= r_side2;
            r_side4 <= r_side3;
            r_side5 <= r_side4;
            r_valid <= r_side5.valid;
        end
        // stage 2: dot product of unit vector and normal
        r_dot   <= r_p1[0] + r_p1[1] + r_p1[2];
        for (int i = 0; i < 3; i++) begin
            // stage 1: unit vector times normal
            r_u1[i] <= n_u[i];
            r_p1[i] <= n_u[i] * $signed(i_side.nrm[i]);
            r_u2[i] <= r_u1[i];
            // stage 3: projection and fuzz products
            r_u3[i] <= r_u2[i];
            r_a[i]  <= r_dot * $signed(r_side2.nrm[i]);
            r_b[i]  <= $signed({1'b0, i_fuzz}) * $signed(r_side2.jit[i]);
            // stage 4: saturated direction
            r_r4[i] <= n_r[i];
            // stage 5: output direction times normal
            r_r5[i] <= r_r4[i];
            r_s5[i] <= r_r4[i] * $signed(r_side4.nrm[i]);
            // stage 6: result registers
            r_dir[i] <= r_r5[i];
        end
        r_scatters <= (sdot > 34'sd0);
    end

    assign o_valid    = r_valid;
    assign o_dir      = r_dir;
    assign o_scatters = r_scatters;

endmodule

[src/msr_checker.sv]
// port-level checks for metal_reflect_scatter, bound to the top level
// depends on msr_pkg and metal_reflect_scatter_defines.svh
`include "metal_reflect_scatter_defines.svh"

module msr_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic signed [msr_pkg::DIR_W-1:0]  i_dir_x,
    input  logic signed [msr_pkg::DIR_W-1:0]  i_dir_y,
    input  logic signed [msr_pkg::DIR_W-1:0]  i_dir_z,
    input  logic                              o_valid,
    input  logic signed [msr_pkg::VEC_W-1:0]  o_out_dir_x,
    input  logic signed [msr_pkg::VEC_W-1:0]  o_out_dir_y,
    input  logic signed [msr_pkg::VEC_W-1:0]  o_out_dir_z,
    input  logic                              o_scatters,
    input  logic [msr_pkg::ALB_W-1:0]         o_atten_red,
    input  logic [msr_pkg::ALB_W-1:0]         o_atten_green,
    input  logic [msr_pkg::ALB_W-1:0]         o_atten_blue
);
    import msr_pkg::*;

    // every accepted item comes out with o_valid high at the end of the pipeline
    `MSR_ASSERT_NEXT(a_latency, start && !busy, ##(MSR_LAT-1) o_valid)

    // a zero direction gives a zero result that does not scatter
    `MSR_ASSERT_NOW(a_zero_dir, start && !busy && i_dir_x == 0 && i_dir_y == 0 && i_dir_z == 0, ##MSR_LAT (o_out_dir_x == 0 && o_out_dir_y == 0 && o_out_dir_z == 0 && !o_scatters))

    // an outward flag needs a nonzero direction
    `MSR_ASSERT_NOW(a_scatter_dir, o_valid && o_scatters, o_out_dir_x != 0 || o_out_dir_y != 0 || o_out_dir_z != 0)

    // attenuation never exceeds one
    `MSR_ASSERT_NOW(a_atten_max, o_valid, o_atten_red <= ALB_ONE && o_atten_green <= ALB_ONE && o_atten_blue <= ALB_ONE)

endmodule

bind metal_reflect_scatter msr_checker u_msr_checker (.*);
